[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the dimmer modules
// Clocked checks on clk, switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off during reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication with the consequent checked on the following cycle
`define ASSERT_NEXT(name, cond, expr, msg) \
	`ASSERT_CLK(name, (cond) |=> (expr), msg)

`endif

[sv/pbd_pkg.sv]
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and codes shared by the push button dimmer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbd_pkg;

	// Item commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Relay requests
	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_ON   = 2'd1;
	localparam logic [1:0] REQ_OFF  = 2'd2;

	// Configuration register indexes
	localparam logic CFG_PRESS_LIMIT = 1'b0;
	localparam logic CFG_LAMP_COUNT  = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0] PRESS_LIMIT_RST = 8'd23;
	localparam logic [3:0] LAMP_COUNT_RST  = 4'd4;

	localparam logic [7:0] LEVEL_MIN = 8'd0;
	localparam logic [7:0] LEVEL_MAX = 8'd255;

	typedef struct packed {
		logic       command;
		logic       button_pressed;
		logic       relay_on;
		logic [7:0] load_level;
	} item_t;

	typedef struct packed {
		logic [1:0] relay_request;
		logic [2:0] lamp_index;
		logic [7:0] lamp_level;
		logic       dim_up;
		logic       last;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic emit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic start_dim;
		logic idx_last;
		logic out_free;
	} ctl_sts_t;

endpackage

[sv/push_button_dimmer.sv]
// ----------------------------------------------------------------------------
// push_button_dimmer
// Single push button light dimmer for one room.
// ----------------------------------------------------------------------------
// Each item is a button tick or a load of all lamp levels and yields one
// result beat per lamp in use (n = lamp_count clamped to 1..MAX_LAMPS),
// lamp 0 first, with last set on the final beat. On a dim tick a scan pass
// over the lamps finds the lowest or highest lamp ahead of the lamp walk;
// the walk holds while the output is stalled. Both passes read the lamp
// level registers through their single read port, one lamp at a time.
// A new item is taken only once the previous item's beats have all left
// the controller; the last beat may still sit in the output register.
// Configuration writes are always taken and must come while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module push_button_dimmer #(
	parameter int MAX_LAMPS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  pbd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pbd_pkg::result_t result
);

	pbd_pkg::ctl_cmd_t cmd;
	pbd_pkg::ctl_sts_t sts;

	// Registers accept a beat every cycle
	assign cfg_ready = 1'b1;

	pbd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	pbd_datapath #(
		.MAX_LAMPS (MAX_LAMPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[sv/pbd_ctrl.sv]
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer: takes an item, runs the extremum scan for a dim step, then
// walks the lamps and emits one result beat per lamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pbd_pkg::ctl_sts_t sts,
	output pbd_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t st_q;

	// Decode commands from the current state
	always_comb begin
		cmd        = '0;
		item_ready = (st_q == ST_IDLE);
		unique case (st_q)
			ST_IDLE: cmd.start = item_valid;
			ST_SCAN: cmd.scan  = 1'b1;
			ST_EMIT: cmd.emit  = sts.out_free;
			default: cmd       = '0;
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (cmd.start) begin
						st_q <= sts.start_dim ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (sts.idx_last) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.emit && sts.idx_last) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_cmd_onehot, $onehot0({cmd.start, cmd.scan, cmd.emit}), "commands overlap")
	`ASSERT_NEXT(a_plain_to_emit, cmd.start && !sts.start_dim, st_q == ST_EMIT, "item without dim did not go to emit")
	`ASSERT_NEXT(a_emit_hold, (st_q == ST_EMIT) && !sts.out_free, st_q == ST_EMIT, "emit left while output stalled")

endmodule

[sv/pbd_datapath.sv]
// ----------------------------------------------------------------------------
// pbd_datapath
// Configuration, press counter, direction, lamp level registers, extremum
// scan and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbd_datapath #(
	parameter int MAX_LAMPS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  pbd_pkg::item_t    item,
	input  pbd_pkg::ctl_cmd_t cmd,
	output pbd_pkg::ctl_sts_t sts,
	output logic              result_valid,
	input  logic              result_ready,
	output pbd_pkg::result_t  result
);

	localparam int IW = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;

	logic [7:0]    thr_q;
	logic [3:0]    cnt_q;
	logic [7:0]    press_q;
	logic          was_held_q;
	logic          dir_q;
	logic [7:0]    lvl_q [MAX_LAMPS];
	logic [IW-1:0] idx_q;
	logic [IW-1:0] last_q;
	logic          relay_q;
	logic          dim_q;
	logic          apply_q;
	logic [7:0]    ext_q;
	logic [1:0]    req_q;
	logic          result_valid_q;
	pbd_pkg::result_t result_q;

	logic [7:0]    p_inc;
	logic          hold_hit;
	logic          toggle;
	logic [4:0]    cnt5;
	logic [4:0]    use_n;
	logic [IW-1:0] n_last;
	logic [7:0]    cur;
	logic [7:0]    eff;
	logic [7:0]    ext_nx;
	logic [7:0]    lvl_nx;

	// Press counter and hold detect for the item on the port
	always_comb begin
		p_inc    = (press_q != pbd_pkg::LEVEL_MAX) ? press_q + 8'd1 : press_q;
		hold_hit = item.button_pressed && (p_inc > thr_q);
		toggle   = !item.button_pressed && (press_q != 8'd0) && (press_q < thr_q);
	end

	// Clamp lamp count to 1..MAX_LAMPS, the lamps present
	always_comb begin
		cnt5 = {1'b0, cnt_q};
		if (cnt_q == 4'd0) begin
			use_n = 5'd1;
		end else if (cnt5 > 5'(MAX_LAMPS)) begin
			use_n = 5'(MAX_LAMPS);
		end else begin
			use_n = cnt5;
		end
		n_last = IW'(use_n - 5'd1);
	end

	// Current lamp, extremum update and stepped level
	always_comb begin
		cur    = lvl_q[idx_q];
		eff    = relay_q ? cur : pbd_pkg::LEVEL_MIN;
		ext_nx = dir_q ? ((eff < ext_q) ? eff : ext_q) : ((eff > ext_q) ? eff : ext_q);
		lvl_nx = cur;
		if (dim_q) begin
			lvl_nx = eff;
			if (apply_q && (eff == ext_q)) begin
				lvl_nx = dir_q ? ext_q + 8'd1 : ext_q - 8'd1;
			end
		end
	end

	always_comb begin
		sts.start_dim = (item.command == pbd_pkg::CMD_TICK) && hold_hit;
		sts.idx_last  = (idx_q == last_q);
		sts.out_free  = !result_valid_q || result_ready;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pbd_pkg::PRESS_LIMIT_RST;
			cnt_q <= pbd_pkg::LAMP_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pbd_pkg::CFG_PRESS_LIMIT: thr_q <= cfg_data;
				pbd_pkg::CFG_LAMP_COUNT:  cnt_q <= cfg_data[3:0];
				default:                  thr_q <= thr_q;
			endcase
		end
	end

	// Item start, extremum scan and lamp walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q    <= '0;
			was_held_q <= 1'b0;
			dir_q      <= 1'b0;
			idx_q      <= '0;
			last_q     <= '0;
			relay_q    <= 1'b0;
			dim_q      <= 1'b0;
			apply_q    <= 1'b0;
			ext_q      <= '0;
			req_q      <= pbd_pkg::REQ_NONE;
			for (int k = 0; k < MAX_LAMPS; k++) begin
				lvl_q[k] <= '0;
			end
		end else begin
			if (cmd.start) begin
				last_q  <= n_last;
				idx_q   <= '0;
				relay_q <= item.relay_on;
				if (item.command == pbd_pkg::CMD_LOAD) begin
					req_q <= pbd_pkg::REQ_NONE;
					dim_q <= 1'b0;
					for (int k = 0; k < MAX_LAMPS; k++) begin
						lvl_q[k] <= item.load_level;
					end
				end else begin
					dim_q      <= hold_hit;
					was_held_q <= hold_hit;
					if (item.button_pressed) begin
						press_q <= hold_hit ? thr_q : p_inc;
					end else begin
						press_q <= '0;
					end
					if (hold_hit) begin
						req_q <= item.relay_on ? pbd_pkg::REQ_NONE : pbd_pkg::REQ_ON;
						ext_q <= dir_q ? pbd_pkg::LEVEL_MAX : pbd_pkg::LEVEL_MIN;
					end else begin
						if (toggle) begin
							req_q <= item.relay_on ? pbd_pkg::REQ_OFF : pbd_pkg::REQ_ON;
						end else begin
							req_q <= pbd_pkg::REQ_NONE;
						end
						// Flip direction when a hold ends
						if (was_held_q) begin
							dir_q <= ~dir_q;
						end
					end
				end
			end

			// Scan for the lowest or highest lamp; flip at the rail
			if (cmd.scan) begin
				ext_q <= ext_nx;
				if (sts.idx_last) begin
					idx_q <= '0;
					if (dir_q) begin
						apply_q <= (ext_nx != pbd_pkg::LEVEL_MAX);
						if (ext_nx == pbd_pkg::LEVEL_MAX) begin
							dir_q <= 1'b0;
						end
					end else begin
						apply_q <= (ext_nx != pbd_pkg::LEVEL_MIN);
						if (ext_nx == pbd_pkg::LEVEL_MIN) begin
							dir_q <= 1'b1;
						end
					end
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end

			// Write back the stepped level and advance
			if (cmd.emit) begin
				lvl_q[idx_q] <= lvl_nx;
				idx_q        <= sts.idx_last ? '0 : idx_q + IW'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.relay_request <= req_q;
			result_q.lamp_index    <= 3'(idx_q);
			result_q.lamp_level    <= lvl_nx;
			result_q.dim_up        <= dir_q;
			result_q.last          <= sts.idx_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_NEXT(a_emit_valid, cmd.emit, result_valid_q, "emitted beat not presented")
	`ASSERT_NEXT(a_emit_last, cmd.emit, result_q.last == $past(idx_q == last_q), "last flag wrong")
	`ASSERT_NEXT(a_start_idx, cmd.start, idx_q == '0, "lamp walk not restarted")

endmodule
